FILE: rtl/core/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    // Default width of the per-string character counter.
    localparam int COUNT_BITS_DEFAULT = 16;

    // Output queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_MAX_CHARS   = 1'b0;
    localparam logic [0:0] REG_SIXTEEN_BIT = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_LEAD  = 3'd1;
    localparam logic [2:0] ERR_CONT  = 3'd2;
    localparam logic [2:0] ERR_TRUNC = 3'd3;
    localparam logic [2:0] ERR_LIMIT = 3'd4;
    localparam logic [2:0] ERR_FFFF  = 3'd5;

    // Value rejected in sixteen-bit mode.
    localparam logic [30:0] CP_REJECT = 31'h0000FFFF;

    // One result as delivered on the output channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] code_point;
        logic [15:0] char_count;
        logic [2:0]  error_code;
        logic        last_of_run;
    } result_t;

    // Results produced by one accepted byte: zero, one or two of them.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

FILE: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: configuration registers, decoder and output queue.
//
// Usage: raw bytes arrive on the in_ valid/ready channel (data_byte, end_of_string);
// decoded results leave on the out_ valid/ready channel (kind, code_point,
// char_count, error_code, last_of_run). Each byte is decoded in the cycle it is
// accepted and its results are written into a four-entry output queue, so the first
// result reaches the outputs from the queue storage, not straight from the byte.
// Throughput is one byte per cycle while in_ready is high. A byte yields zero, one
// or two results; the queue drains one result per cycle while out_ready is high,
// and a byte that finishes a string with a character yields the character and then
// the done result. in_ready is high while at least two queue entries are free, which
// lets bytes stream without gaps as long as the receiver keeps up.
// When the receiver stalls, results wait in the queue and in_ready falls once
// fewer than two entries remain; nothing is dropped. Reset clears the decoder state
// and empties the queue; max_chars returns to 65535 and sixteen-bit mode is off.
// Registers must be written over the APB port (max_chars at 0x0, sixteen_bit_target
// at 0x4) while no string is in flight; the block does not enforce this.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // Byte input channel.
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_string,
    // Result output channel.
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [1:0]        kind,
    output logic      [30:0]       code_point,
    output logic      [15:0]       char_count,
    output logic      [2:0]        error_code,
    output logic                   last_of_run
);

    logic [15:0] max_chars_reg;
    logic        sixteen_reg;
    logic        cfg_write;
    logic        fire;
    push_t       push;
    result_t     head;

    // Register access decode; the port never waits.
    always_comb
    begin
        pready    = 1'b1;
        cfg_write = psel && penable && pwrite && pready;
        if (paddr[2] == REG_SIXTEEN_BIT)
        begin
            prdata = DATA_W'(sixteen_reg);
        end
        else
        begin
            prdata = DATA_W'(max_chars_reg);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= 16'hFFFF;
            sixteen_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MAX_CHARS)
            begin
                max_chars_reg <= pwdata[15:0];
            end
            else
            begin
                sixteen_reg <= pwdata[0];
            end
        end
    end

    // Accepted byte request.
    assign fire = in_valid && in_ready;

    u8sd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .max_chars     (max_chars_reg),
        .sixteen_bit   (sixteen_reg),
        .push          (push)
    );

    u8sd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Result fields from the queue head.
    always_comb
    begin
        kind        = head.kind;
        code_point  = head.code_point;
        char_count  = head.char_count;
        error_code  = head.error_code;
        last_of_run = head.last_of_run;
    end

endmodule

`default_nettype wire

FILE: rtl/core/u8sd_decode.sv
// Byte decoder: sequence state, per-string count and result generation.
`default_nettype none

module u8sd_decode
    import u8sd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_string,
    input  wire logic [15:0] max_chars,
    input  wire logic        sixteen_bit,
    output push_t            push
);

    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [2:0]            pend_reg, pend_next;
    logic [30:0]           pv_reg, pv_next;
    logic [COUNT_BITS-1:0] chars_reg, chars_next, chars_inc;
    logic                  disc_reg, disc_next;

    logic [2:0]       lead_len;
    logic [7:0]       lead_mask;
    logic [30:0]      cont_value, fin_value;
    logic             do_finish;
    logic [2:0]       fail_code;
    logic [LIM_W-1:0] count_max, limit_ext, chars_ext, done_ext;
    logic             over_limit;

    // Limit is max_chars clipped to what the counter can hold.
    always_comb
    begin
        count_max  = LIM_W'({COUNT_BITS{1'b1}});
        limit_ext  = (LIM_W'(max_chars) > count_max) ? count_max : LIM_W'(max_chars);
        chars_ext  = LIM_W'(chars_reg);
        over_limit = (chars_ext >= limit_ext);
    end

    // Lead byte classification.
    always_comb
    begin
        case (data_byte) inside
            [8'h00:8'h7F]: begin lead_len = 3'd1; lead_mask = 8'h7F; end
            [8'hC0:8'hDF]: begin lead_len = 3'd2; lead_mask = 8'h1F; end
            [8'hE0:8'hEF]: begin lead_len = 3'd3; lead_mask = 8'h0F; end
            [8'hF0:8'hF7]: begin lead_len = 3'd4; lead_mask = 8'h07; end
            [8'hF8:8'hFB]: begin lead_len = 3'd5; lead_mask = 8'h03; end
            [8'hFC:8'hFD]: begin lead_len = 3'd6; lead_mask = 8'h01; end
            default:       begin lead_len = 3'd0; lead_mask = 8'h00; end
        endcase
    end

    // Next state and results for the byte being accepted.
    always_comb
    begin
        pend_next  = pend_reg;
        pv_next    = pv_reg;
        chars_next = chars_reg;
        disc_next  = disc_reg;
        do_finish  = 1'b0;
        fin_value  = '0;
        fail_code  = ERR_NONE;
        chars_inc  = chars_reg + 1'b1;
        done_ext   = LIM_W'(chars_inc);
        cont_value = {pv_reg[24:0], data_byte[5:0]};
        push       = '0;

        if (fire)
        begin
            if (disc_reg)
            begin
                // Skipping a failed string until its last byte.
                if (end_of_string)
                begin
                    disc_next = 1'b0;
                end
            end
            else if (pend_reg == 3'd0)
            begin
                // Lead position.
                if (over_limit)
                begin
                    fail_code = ERR_LIMIT;
                end
                else if (lead_len == 3'd0 || (sixteen_bit && lead_len > 3'd3))
                begin
                    fail_code = ERR_LEAD;
                end
                else if (lead_len == 3'd1)
                begin
                    do_finish = 1'b1;
                    fin_value = 31'(data_byte & lead_mask);
                end
                else if (end_of_string)
                begin
                    fail_code = ERR_TRUNC;
                end
                else
                begin
                    pend_next = lead_len - 3'd1;
                    pv_next   = 31'(data_byte & lead_mask);
                end
            end
            else
            begin
                // Continuation position.
                if (data_byte[7:6] != 2'b10)
                begin
                    fail_code = ERR_CONT;
                end
                else if (pend_reg == 3'd1)
                begin
                    do_finish = 1'b1;
                    fin_value = cont_value;
                end
                else if (end_of_string)
                begin
                    fail_code = ERR_TRUNC;
                end
                else
                begin
                    pend_next = pend_reg - 3'd1;
                    pv_next   = cont_value;
                end
            end

            // A completed character, possibly ending the string.
            if (do_finish)
            begin
                pend_next = 3'd0;
                pv_next   = '0;
                if (sixteen_bit && fin_value == CP_REJECT)
                begin
                    fail_code = ERR_FFFF;
                end
                else
                begin
                    push.r0.kind       = KIND_CHAR;
                    push.r0.code_point = fin_value;
                    if (end_of_string)
                    begin
                        push.cnt           = 2'd2;
                        push.r1.kind       = KIND_DONE;
                        push.r1.char_count = done_ext[15:0];
                        push.r1.last_of_run = 1'b1;
                        chars_next         = '0;
                    end
                    else
                    begin
                        push.cnt            = 2'd1;
                        push.r0.last_of_run = 1'b1;
                        chars_next          = chars_inc;
                    end
                end
            end

            // Any failure gives a single error result and ends the string.
            if (fail_code != ERR_NONE)
            begin
                push                = '0;
                push.cnt            = 2'd1;
                push.r0.kind        = KIND_ERR;
                push.r0.error_code  = fail_code;
                push.r0.last_of_run = 1'b1;
                pend_next           = 3'd0;
                pv_next             = '0;
                chars_next          = '0;
                disc_next           = !end_of_string;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 3'd0;
            pv_reg    <= '0;
            chars_reg <= '0;
            disc_reg  <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            pv_reg    <= pv_next;
            chars_reg <= chars_next;
            disc_reg  <= disc_next;
        end
    end

    // While skipping, no sequence is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> pend_reg == 3'd0)
        else $error("sequence pending while skipping a string");

    // A skipped byte never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && disc_reg |-> push.cnt == 2'd0)
        else $error("result produced for a skipped byte");

    // Two results are always a character followed by the done result.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.r0.kind == KIND_CHAR && push.r1.kind == KIND_DONE
                             && !push.r0.last_of_run)
        else $error("malformed result pair");

endmodule

`default_nettype wire

FILE: rtl/core/u8sd_fifo.sv
// Output result queue: takes up to two results a cycle, hands out one while out_ready is high.
`default_nettype none

module u8sd_fifo
    import u8sd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    output logic        space_ok,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     head
);

    result_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    // Handshake and pointer arithmetic.
    always_comb
    begin
        out_valid   = (count_reg != '0);
        space_ok    = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
        pop         = out_valid && out_ready;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_p1   = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // Results arrive only while two entries are free.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> space_ok)
        else $error("results pushed without room");

    // Fill count tracks the pointers.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'(0) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

FILE: bench/utf8_stream_decoder_tb.sv
// Self-checking testbench for the UTF-8 stream decoder, with its own decoder model.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb
    import u8sd_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // One byte request as presented on the input channel.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } byte_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_string = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [30:0] code_point;
    logic [15:0] char_count;
    logic [2:0]  error_code;
    logic        last_of_run;

    // Bytes waiting to be sent, bytes of the string being built, and results still owed.
    byte_req_t   byte_stream[$];
    logic [7:0]  staged[$];
    result_t     pending_results[$];

    // Decoder model state and its copy of the registers.
    logic [2:0]  cont_left = '0;
    logic [30:0] accum = '0;
    logic [15:0] chars_in_string = '0;
    logic        skipping = 1'b0;
    logic [15:0] cfg_max_chars = 16'hFFFF;
    logic        cfg_bmp_only = 1'b0;

    // Idle controls for each side, changed between phases.
    logic        send_gaps = 1'b0;
    logic        recv_stalls = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    utf8_stream_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_string(end_of_string),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .code_point   (code_point),
        .char_count   (char_count),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(input logic enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_result(input logic [1:0] k, input logic [30:0] cp,
                                         input logic [15:0] cnt, input logic [2:0] err,
                                         input logic lst);
        result_t r;
        r.kind = k;
        r.code_point = cp;
        r.char_count = cnt;
        r.error_code = err;
        r.last_of_run = lst;
        pending_results.push_back(r);
    endfunction

    // A failure ends the string: one error, then skip to its last byte.
    function automatic void fail_string(input logic [2:0] err, input logic lst);
        queue_result(KIND_ERR, '0, '0, err, 1'b1);
        cont_left = '0;
        accum = '0;
        chars_in_string = '0;
        skipping = !lst;
    endfunction

    function automatic void finish_char(input logic lst);
        logic [30:0] v;
        v = accum;
        cont_left = '0;
        accum = '0;
        if (cfg_bmp_only && v == CP_REJECT)
        begin
            fail_string(ERR_FFFF, lst);
            return;
        end
        chars_in_string = chars_in_string + 16'd1;
        if (!lst)
        begin
            queue_result(KIND_CHAR, v, '0, ERR_NONE, 1'b1);
        end
        else
        begin
            queue_result(KIND_CHAR, v, '0, ERR_NONE, 1'b0);
            queue_result(KIND_DONE, '0, chars_in_string, ERR_NONE, 1'b1);
            chars_in_string = '0;
            skipping = 1'b0;
        end
    endfunction

    // Works out the results that one accepted byte must cause.
    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        int unsigned seq_len;
        logic [7:0]  lead_mask;
        if (skipping)
        begin
            if (lst)
            begin
                skipping = 1'b0;
                cont_left = '0;
                accum = '0;
                chars_in_string = '0;
            end
            return;
        end
        if (cont_left == 0)
        begin
            if (chars_in_string >= cfg_max_chars)
            begin
                fail_string(ERR_LIMIT, lst);
                return;
            end
            seq_len = 0;
            lead_mask = 8'h00;
            casez (b)
                8'b0???_????: begin seq_len = 1; lead_mask = 8'h7F; end
                8'b110?_????: begin seq_len = 2; lead_mask = 8'h1F; end
                8'b1110_????: begin seq_len = 3; lead_mask = 8'h0F; end
                8'b1111_0???: begin seq_len = 4; lead_mask = 8'h07; end
                8'b1111_10??: begin seq_len = 5; lead_mask = 8'h03; end
                8'b1111_110?: begin seq_len = 6; lead_mask = 8'h01; end
                default:      seq_len = 0;
            endcase
            if (seq_len == 0 || (cfg_bmp_only && seq_len > 3))
            begin
                fail_string(ERR_LEAD, lst);
                return;
            end
            accum = {23'd0, b & lead_mask};
            if (seq_len == 1)
                finish_char(lst);
            else if (lst)
                fail_string(ERR_TRUNC, lst);
            else
                cont_left = 3'(seq_len - 1);
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            fail_string(ERR_CONT, lst);
            return;
        end
        accum = {accum[24:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0)
            finish_char(lst);
        else if (lst)
            fail_string(ERR_TRUNC, lst);
    endfunction

    // Appends one character of the given length to the string being built.
    function automatic void stage_char(input int unsigned len, input logic [30:0] v);
        logic [7:0]  prefix;
        logic [7:0]  lead_mask;
        logic [30:0] upper;
        int          k;
        if (len == 1)
        begin
            staged.push_back({1'b0, v[6:0]});
            return;
        end
        case (len)
            2:       begin prefix = 8'hC0; lead_mask = 8'h1F; end
            3:       begin prefix = 8'hE0; lead_mask = 8'h0F; end
            4:       begin prefix = 8'hF0; lead_mask = 8'h07; end
            5:       begin prefix = 8'hF8; lead_mask = 8'h03; end
            default: begin prefix = 8'hFC; lead_mask = 8'h01; end
        endcase
        upper = v >> (6 * (len - 1));
        staged.push_back(prefix | (upper[7:0] & lead_mask));
        for (k = int'(len) - 2; k >= 0; k--)
        begin
            upper = v >> (6 * k);
            staged.push_back({2'b10, upper[5:0]});
        end
    endfunction

    // Moves the built string to the send queue, marking its final byte.
    function automatic void flush_string();
        byte_req_t r;
        int        k;
        for (k = 0; k < staged.size(); k++)
        begin
            r.value = staged[k];
            r.last = (k == staged.size() - 1);
            byte_stream.push_back(r);
        end
        staged.delete();
    endfunction

    // Queues n bytes taken from the low end of a packed word, first byte highest.
    function automatic void add_bytes(input logic [63:0] bytes, input int n, input logic fin);
        byte_req_t r;
        int        k;
        for (k = n - 1; k >= 0; k--)
        begin
            r.value = bytes[8*k +: 8];
            r.last = fin && (k == 0);
            byte_stream.push_back(r);
        end
    endfunction

    // One random string: mostly well formed, the rest corrupted, cut short or noise.
    function automatic void add_random_string(input logic bmp);
        int unsigned pick;
        int unsigned nch;
        int unsigned len;
        int unsigned bits;
        int unsigned r;
        int unsigned k;
        logic [30:0] v;
        pick = $urandom_range(0, 99);
        nch = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (k = 0; k < nch; k++)
        begin
            r = $urandom_range(0, 9);
            if (bmp)
                len = $urandom_range(1, 3);
            else
                len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 7) ? 3 : (r < 8) ? 4 : (r < 9) ? 5 : 6;
            bits = (len == 1) ? 7 : 5 * len + 1;
            v = 31'($urandom) & 31'((64'd1 << bits) - 1);
            if (bmp && $urandom_range(0, 19) == 0)
            begin
                len = 3;
                v = CP_REJECT;
            end
            stage_char(len, v);
        end
        if (pick >= 70 && pick < 82)
        begin
            // Overwrite one byte with anything.
            k = $urandom_range(0, staged.size() - 1);
            staged[k] = 8'($urandom);
        end
        else if (pick >= 82 && pick < 90 && staged.size() > 1)
        begin
            // Cut the string short, often inside a character.
            r = $urandom_range(1, staged.size() - 1);
            for (k = 0; k < r; k++)
                void'(staged.pop_back());
        end
        else if (pick >= 90)
        begin
            staged.delete();
            r = $urandom_range(1, 6);
            for (k = 0; k < r; k++)
                staged.push_back(8'($urandom));
        end
        flush_string();
    endfunction

    // Byte driver: presents queued requests, with random gaps between them.
    always @(posedge clk)
    begin : drive_bytes
        byte_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            end_of_string <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_string);
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_stream.size() != 0)
                begin
                    nxt = byte_stream.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.value;
                    end_of_string <= nxt.last;
                    send_wait <= pick_gap(send_gaps);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_failure(input string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Result monitor: compares every accepted result with the oldest one owed.
    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_failure($sformatf({"unexpected result kind %0d cp %h cnt %0d ",
                                            "err %0d last %0d"},
                                           kind, code_point, char_count, error_code,
                                           last_of_run));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind || code_point !== want.code_point
                        || char_count !== want.char_count || error_code !== want.error_code
                        || last_of_run !== want.last_of_run)
                    begin
                        flag_failure($sformatf({"expected kind %0d cp %h cnt %0d err %0d last %0d, ",
                                                "got kind %0d cp %h cnt %0d err %0d last %0d"},
                                               want.kind, want.code_point, want.char_count,
                                               want.error_code, want.last_of_run, kind,
                                               code_point, char_count, error_code,
                                               last_of_run));
                    end
                end
            end
            if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_wait <= pick_gap(recv_stalls);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("utf8_stream_decoder: mismatch");
            $finish;
        end
    end

    // Register write over the configuration port, a setup phase and then an access phase;
    // it leaves the port idle before returning.
    task automatic write_reg(input logic [0:0] idx, input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MAX_CHARS)
            cfg_max_chars = val[15:0];
        else
            cfg_bmp_only = val[0];
        @(posedge clk);
    endtask

    // Waits until every byte is taken and every result has come, then lets the design settle.
    task automatic drain();
        while (byte_stream.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sequence of phases: directed strings first, then random strings per setting.
    initial
    begin : run_phases
        logic [15:0] limits[9];
        logic        modes[9];
        int unsigned sizes[9];
        int unsigned start_size;
        int          p;
        limits = '{16'hFFFF, 16'hFFFF, 16'd2, 16'd3, 16'd0, 16'd1, 16'd5, 16'hFFFE, 16'hFFFF};
        modes  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        sizes  = '{200, 180, 150, 150, 30, 100, 150, 200, 180};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leads of one to four bytes and of six bytes, then lead, continuation and truncation failures.
        add_bytes(64'h007F_C280, 4, 1'b0);
        add_bytes(64'hE08080_F0808080, 7, 1'b0);
        add_bytes(64'hFDBF_BFBF_BFBF, 6, 1'b1);
        add_bytes(64'hFF4141, 3, 1'b1);
        add_bytes(64'h80, 1, 1'b1);
        add_bytes(64'hFE, 1, 1'b1);
        add_bytes(64'hC241, 2, 1'b1);
        add_bytes(64'hE080, 2, 1'b1);
        add_bytes(64'hC2, 1, 1'b1);
        drain();

        // Zero limit, then a small limit with sixteen-bit mode.
        write_reg(REG_MAX_CHARS, 32'd0);
        add_bytes(64'h41, 1, 1'b1);
        drain();
        write_reg(REG_MAX_CHARS, 32'd2);
        write_reg(REG_SIXTEEN_BIT, 32'd1);
        add_bytes(64'h414243, 3, 1'b1);
        add_bytes(64'hF0, 1, 1'b1);
        add_bytes(64'hEFBFBF, 3, 1'b1);
        add_bytes(64'hEDA080, 3, 1'b1);
        drain();

        for (p = 0; p < 9; p++)
        begin
            write_reg(REG_MAX_CHARS, {16'd0, limits[p]});
            write_reg(REG_SIXTEEN_BIT, {31'd0, modes[p]});
            send_gaps <= (p % 4 == 0) || (p % 4 == 2);
            recv_stalls <= (p % 4 == 0) || (p % 4 == 3);
            start_size = 0;
            while (start_size < sizes[p])
            begin
                add_random_string(modes[p]);
                start_size = start_size + staged.size() + 1;
                start_size = start_size + 0;
                start_size = byte_stream.size() > start_size ? byte_stream.size() : start_size;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("utf8_stream_decoder: match");
        else
            $display("utf8_stream_decoder: mismatch");
        $finish;
    end

endmodule
